>>> rtl/plab_pkg.sv
// Shared types and constants of the PIN attempt lockout block.
// No dependencies; used by every module of the block.
package plab_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_LOCKED   = 2'd1,
      STATUS_WRONG    = 2'd2,
      STATUS_WIPED    = 2'd3
   } status_type;

   // Register map: byte address bits [2:2] select the register
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_MAX_ATTEMPTS = 1'b0;
   localparam logic [0:0] REG_BASE_SECONDS = 1'b1;

   localparam logic [7:0]  MAX_ATTEMPTS_RESET = 8'd10;
   localparam logic [11:0] BASE_SECONDS_RESET = 12'd30;

   localparam logic [11:0] WAIT_CAP_S   = 12'd3600;
   localparam logic [9:0]  MS_PER_S     = 10'd1000;
   // Smallest millisecond distance whose second count exceeds the cap; it reads as the cap
   localparam logic [31:0] REMAIN_SAT_MS = 32'd3601000;
   // floor(y / 125) == (y * DIV125_RECIP) >> DIV125_SHIFT, exact for y < 2**19
   localparam logic [19:0] DIV125_RECIP = 20'd536871;
   localparam int          DIV125_SHIFT = 26;
   localparam logic [7:0]  SHIFT_CAP    = 8'd12;
   localparam logic [7:0]  COUNT_MAX    = 8'd255;

   typedef struct packed {
      logic [7:0]  max_attempts;
      logic [11:0] base_seconds;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  failures;
      logic [31:0] deadline_ms;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [11:0] remaining_s;
      logic [7:0]  attempt_count;
      logic [11:0] wait_s;
   } result_type;

endpackage

>>> rtl/plab_csr.sv
// Configuration registers of the PIN attempt lockout block, APB-style access.
// Depends on plab_pkg.
module plab_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [plab_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output plab_pkg::cfg_type                cfg
);

   logic [7:0]  max_attempts_ff;
   logic [11:0] base_seconds_ff;
   logic        write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff <= plab_pkg::MAX_ATTEMPTS_RESET;
         base_seconds_ff <= plab_pkg::BASE_SECONDS_RESET;
      end else if (write_en) begin
         case (csr_paddr[2:2])
            plab_pkg::REG_MAX_ATTEMPTS: max_attempts_ff <= csr_pwdata[7:0];
            plab_pkg::REG_BASE_SECONDS: base_seconds_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2:2])
         plab_pkg::REG_MAX_ATTEMPTS: csr_prdata = {24'd0, max_attempts_ff};
         plab_pkg::REG_BASE_SECONDS: csr_prdata = {20'd0, base_seconds_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   assign cfg.max_attempts = max_attempts_ff;
   assign cfg.base_seconds = base_seconds_ff;

endmodule

>>> rtl/plab_eval.sv
// Decision logic for one PIN attempt: lockout test, count update, backoff.
// Depends on plab_pkg.
module plab_eval (
   input  plab_pkg::cfg_type    cfg,
   input  plab_pkg::state_type  st,
   input  logic [31:0]          now_ms,
   input  logic                 pin_matches,
   output plab_pkg::result_type result,
   output plab_pkg::state_type  st_next
);

   logic        locked;
   logic [31:0] diff_ms;
   logic [18:0] diff_8ms;
   logic [38:0] quot_prod;
   logic [11:0] remaining;
   logic [7:0]  count_inc;
   logic [7:0]  shift;
   logic        wipe;
   logic [22:0] shifted;
   logic [11:0] wait_sec;
   logic [32:0] end_sum;
   logic [31:0] end_ms;

   assign locked   = now_ms < st.deadline_ms;
   assign diff_ms  = st.deadline_ms - now_ms;
   // Divide by 1000: drop three bits, then multiply by the reciprocal of 125
   assign diff_8ms  = diff_ms[21:3];
   assign quot_prod = 39'(diff_8ms) * 39'(plab_pkg::DIV125_RECIP);
   assign remaining = (diff_ms >= plab_pkg::REMAIN_SAT_MS) ? plab_pkg::WAIT_CAP_S
                    : quot_prod[plab_pkg::DIV125_SHIFT +: 12];

   assign count_inc = (st.failures == plab_pkg::COUNT_MAX) ? st.failures
                    : st.failures + 8'd1;
   assign wipe      = count_inc >= cfg.max_attempts;

   // Backoff: base << (count - 1), capped
   assign shift   = count_inc - 8'd1;
   assign shifted = 23'(cfg.base_seconds) << shift[3:0];
   always_comb begin
      if (cfg.base_seconds == 12'd0) begin
         wait_sec = 12'd0;
      end else if (shift >= plab_pkg::SHIFT_CAP) begin
         wait_sec = plab_pkg::WAIT_CAP_S;
      end else if (shifted > 23'(plab_pkg::WAIT_CAP_S)) begin
         wait_sec = plab_pkg::WAIT_CAP_S;
      end else begin
         wait_sec = shifted[11:0];
      end
   end

   // Saturate the deadline instead of wrapping
   assign end_sum = 33'(now_ms) + 33'(wait_sec) * 33'(plab_pkg::MS_PER_S);
   assign end_ms  = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];

   always_comb begin
      st_next              = st;
      result.status        = plab_pkg::STATUS_ACCEPTED;
      result.remaining_s   = 12'd0;
      result.wait_s        = 12'd0;
      if (locked) begin
         result.status      = plab_pkg::STATUS_LOCKED;
         result.remaining_s = remaining;
      end else if (pin_matches) begin
         st_next.failures = 8'd0;
      end else if (wipe) begin
         st_next.failures = 8'd0;
         result.status    = plab_pkg::STATUS_WIPED;
      end else begin
         st_next.failures    = count_inc;
         st_next.deadline_ms = end_ms;
         result.status       = plab_pkg::STATUS_WRONG;
         result.wait_s       = wait_sec;
      end
      result.attempt_count = st_next.failures;
   end

endmodule

>>> rtl/pin_attempt_lockout_backoff.sv
// PIN attempt lockout with exponential backoff: top level.
// Depends on plab_pkg, plab_csr and plab_eval.
//
// Usage:
//   req_* carries one PIN attempt per transfer: the millisecond time in
//   tdata and the external PIN check verdict in tuser. rsp_* returns one
//   result per attempt, in order: status in tuser, the remaining and newly
//   armed lockout seconds and the failure count in tdata.
//   csr_* is an APB-style port for max_attempts (0x0) and base_seconds (0x4);
//   write it only while no attempt is in flight.
// Timing:
//   An attempt is registered at its input transfer, then evaluated against
//   the failure count and deadline; its result is registered in the result
//   register, which drives rsp_tvalid. One attempt per cycle is sustained
//   while rsp_tready stays high; the count and deadline update at the
//   same edge that loads the result register, so the next attempt sees them.
// Reset:
//   Synchronous; clears both stages, the failure count and the deadline, and
//   loads the register defaults (10 attempts, 30 seconds).
// Stall:
//   While rsp_tready is low the result holds; one more attempt is taken into
//   the input register, then req_tready drops until the result moves.
module pin_attempt_lockout_backoff (
   input  logic                             clock,
   input  logic                             reset,
   // APB-style configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [plab_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   // Attempt channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,  // [31:0] now_ms
   input  logic                             req_tuser,  // [0] pin_matches
   // Result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [11:0] remaining_s, [19:12] attempt_count, [31:20] wait_s
   output logic [31:0]                      rsp_tdata,
   output logic [1:0]                       rsp_tuser   // [1:0] status
);

   plab_pkg::cfg_type    cfg;
   plab_pkg::state_type  st_ff;
   plab_pkg::state_type  st_in;
   plab_pkg::result_type result_in;
   plab_pkg::result_type result_ff;

   logic        in_valid_ff;
   logic [31:0] now_ms_ff;
   logic        pin_matches_ff;
   logic        rsp_valid_ff;
   logic        advance;

   plab_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Move the registered attempt into the result register when it is free
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Hold the attempt payload until it moves on
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ms_ff      <= req_tdata;
         pin_matches_ff <= req_tuser;
      end
   end

   plab_eval u_eval (
      .cfg         (cfg),
      .st          (st_ff),
      .now_ms      (now_ms_ff),
      .pin_matches (pin_matches_ff),
      .result      (result_in),
      .st_next     (st_in)
   );

   // Commit the count and deadline with the result so back-to-back
   // attempts see each other's effect
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.failures    <= 8'd0;
         st_ff.deadline_ms <= 32'd0;
         rsp_valid_ff      <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {result_ff.wait_s, result_ff.attempt_count, result_ff.remaining_s};
   assign rsp_tuser  = result_ff.status;

endmodule

>>> rtl/plab_checker.sv
// Port-level checks of the PIN attempt lockout block, bound to the top level.
// Depends on plab_pkg and pin_attempt_lockout_backoff.
module plab_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result in the first cycle out of reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Accepted and wiped attempts leave the count cleared and arm nothing
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == plab_pkg::STATUS_ACCEPTED ||
                     rsp_tuser == plab_pkg::STATUS_WIPED) |->
         rsp_tdata[19:12] == 8'd0 && rsp_tdata[31:20] == 12'd0 &&
         rsp_tdata[11:0] == 12'd0)
      else $error("accept or wipe with nonzero count or wait");

   // Second counts stay within the cap and match the status
   a_wait_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:0] <= plab_pkg::WAIT_CAP_S &&
         rsp_tdata[31:20] <= plab_pkg::WAIT_CAP_S &&
         (rsp_tuser == plab_pkg::STATUS_WRONG || rsp_tdata[31:20] == 12'd0))
      else $error("second count out of range");

endmodule

bind pin_attempt_lockout_backoff plab_checker u_plab_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
